// ----- rtl/ssm_pkg.sv -----
// Package for the sorted sequence merge block: field widths, default depth,
// item kind codes and the controller/datapath command and status structs.
// Depends on nothing; the controller, datapath and top level import it.
`timescale 1ns / 1ps

package ssm_pkg;

  // Widths of the word fields.
  localparam int VALUE_W   = 32;
  localparam int KIND_W    = 2;

  // Default number of entries in each sequence store.
  localparam int DEPTH_DEF = 32;

  // What an input word asks for.
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MERGE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_first;   // append the input value to the first store
    logic wr_second;  // append the input value to the second store
    logic rst_idx;    // start a merge: both heads back to entry zero
    logic emit;       // move the selected head into the output register
  } ssm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // both stores hold nothing
    logic slot_free;  // output register can take a word this cycle
    logic final_pick; // the next word emitted is the last of the run
  } ssm_sts_t;

endpackage

// ----- rtl/ssm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the datapath instances it once per sequence store.
`timescale 1ns / 1ps

module ssm_ram #(
  parameter int W  = 32,
  parameter int D  = 32,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Write port and registered read port; a read sees writes of earlier edges.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ssm_ctrl.sv -----
// Controller of the sorted sequence merge block: decodes input words and
// sequences a merge one emitted word at a time. Depends on ssm_pkg.
`timescale 1ns / 1ps

module ssm_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic [ssm_pkg::KIND_W-1:0] in_kind,
  output logic                      in_tready,
  input  ssm_pkg::ssm_sts_t         sts,
  output ssm_pkg::ssm_cmd_t         cmd
);

  import ssm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd.wr_first  = 1'b0;
    cmd.wr_second = 1'b0;
    cmd.rst_idx   = 1'b0;
    cmd.emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_FIRST:  cmd.wr_first  = 1'b1;
            KIND_SECOND: cmd.wr_second = 1'b1;
            KIND_MERGE: begin
              // An empty merge emits nothing and leaves the block idle.
              cmd.rst_idx = 1'b1;
              if (!sts.empty) begin
                state_nxt = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.final_pick) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/ssm_dp.sv -----
// Datapath of the sorted sequence merge block: two sequence stores, their
// fill counts and head indexes, the head compare and the output register.
// Depends on ssm_pkg and ssm_ram.
`timescale 1ns / 1ps

module ssm_dp #(
  parameter int DEPTH = ssm_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ssm_pkg::VALUE_W-1:0] in_value,
  input  ssm_pkg::ssm_cmd_t           cmd,
  output ssm_pkg::ssm_sts_t           sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ssm_pkg::VALUE_W-1:0] out_value,
  output logic                        out_last
);

  import ssm_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0]      cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0]      idx_a_r, idx_a_nxt, idx_b_r, idx_b_nxt;
  logic [VALUE_W-1:0] head_a, head_b;
  logic               we_a, we_b;
  logic               a_left, b_left, take_a;
  logic [CW:0]        done_cnt, total_cnt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_last_r;

  // Appends go to the next free entry; a full store ignores them.
  assign we_a = cmd.wr_first  && (cnt_a_r < CW'(DEPTH));
  assign we_b = cmd.wr_second && (cnt_b_r < CW'(DEPTH));

  // The read address follows the next head index, so the registered read
  // data is always the current head.
  ssm_ram #(.W(VALUE_W), .D(DEPTH), .AW(AW)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (in_value),
    .raddr (idx_a_nxt[AW-1:0]),
    .rdata (head_a)
  );

  ssm_ram #(.W(VALUE_W), .D(DEPTH), .AW(AW)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (in_value),
    .raddr (idx_b_nxt[AW-1:0]),
    .rdata (head_b)
  );

  // Head compare: the first sequence wins ties, which keeps the merge stable.
  assign a_left = idx_a_r < cnt_a_r;
  assign b_left = idx_b_r < cnt_b_r;
  assign take_a = a_left && (!b_left || ($signed(head_a) <= $signed(head_b)));

  assign done_cnt  = {1'b0, idx_a_r} + {1'b0, idx_b_r};
  assign total_cnt = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};

  assign sts.empty      = (total_cnt == '0);
  assign sts.slot_free  = !out_valid_r || out_tready;
  assign sts.final_pick = ((done_cnt + {{CW{1'b0}}, 1'b1}) == total_cnt);

  // Counts and head indexes; the last emitted word empties both stores.
  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    idx_a_nxt = idx_a_r;
    idx_b_nxt = idx_b_r;
    if (we_a) begin
      cnt_a_nxt = cnt_a_r + CW'(1);
    end
    if (we_b) begin
      cnt_b_nxt = cnt_b_r + CW'(1);
    end
    if (cmd.rst_idx) begin
      idx_a_nxt = '0;
      idx_b_nxt = '0;
    end else if (cmd.emit) begin
      if (sts.final_pick) begin
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        idx_a_nxt = '0;
        idx_b_nxt = '0;
      end else if (take_a) begin
        idx_a_nxt = idx_a_r + CW'(1);
      end else begin
        idx_b_nxt = idx_b_r + CW'(1);
      end
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      idx_a_r     <= '0;
      idx_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      idx_a_r     <= idx_a_nxt;
      idx_b_r     <= idx_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= take_a ? head_a : head_b;
      out_last_r  <= sts.final_pick;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  // A store never holds more than its depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CW'(DEPTH)) && (cnt_b_r <= CW'(DEPTH)))
    else $error("sequence store count above depth");

  // A head index never runs past its store's fill.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_a_r <= cnt_a_r) && (idx_b_r <= cnt_b_r))
    else $error("head index beyond stored elements");

  // A word is only emitted while some stored element is still unread.
  a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (a_left || b_left))
    else $error("emit with both sequences exhausted");

  // The last word of a run leaves both stores empty.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.final_pick) |=> (cnt_a_r == '0) && (cnt_b_r == '0))
    else $error("stores not emptied after final word");

endmodule

// ----- rtl/sorted_sequence_merge.sv -----
// Top level of the sorted sequence merge block: joins the controller and
// the datapath. Depends on ssm_pkg, ssm_ctrl, ssm_dp and ssm_ram.
`timescale 1ns / 1ps

// Each input word either appends a signed 32-bit value to the first or second
// store (up to DEPTH each; further appends are dropped) or commands a merge.
// Appends stream at one word per clock while no merge is in progress. Once a
// merge command is taken, the input is held off while the stored values leave
// in nondecreasing order, one per cycle while out_tready is high, ties taken
// from the first sequence. The pace is set by the one-head-per-cycle compare
// against the registered read ports of the two stores. The final word of a
// run carries out_tlast and both stores are then empty. A merge with nothing
// stored emits nothing, and kind 3 is ignored. Store contents are not cleared
// at reset; only the fill counts, head indexes and output valid flag are.

module sorted_sequence_merge #(
  parameter int DEPTH = ssm_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ssm_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic [ssm_pkg::KIND_W-1:0]  in_tuser,   // [1:0] kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ssm_pkg::VALUE_W-1:0] out_tdata,  // [31:0] merged_value
  output logic                        out_tlast
);

  import ssm_pkg::*;

  ssm_cmd_t cmd;
  ssm_sts_t sts;

  // Sequencing of appends and merges.
  ssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stores, compare and output register.
  ssm_dp #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
